FILE: sv/arpc_pkg.sv
package arpc_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 48;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATION_IP = 1'b0;

    localparam logic        OP_RESOLVE  = 1'b0;
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    localparam logic [1:0] ACT_ANSWER  = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_REPLY   = 2'd2;
    localparam logic [1:0] ACT_FULL    = 2'd3;

    localparam logic [7:0]  BCAST_BYTE = 8'hff;
    localparam logic [47:0] BCAST_MAC  = {6{BCAST_BYTE}};

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        op;
        logic [15:0] arp_opcode;
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] client_id;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] out_ip;
        logic [47:0] out_mac;
        logic [15:0] out_client;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_RESOLVE,
        CMD_LEARN,
        CMD_RESPOND
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] client;
    } t_cmd;

endpackage

FILE: sv/arpc_ram.sv
module arpc_ram #(
    parameter int unsigned WIDTH = 65,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/arpc_front.sv
module arpc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [arpc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  arpc_pkg::t_in_word                   i_in_word,
    output logic                                 o_cmd_valid,
    input  logic                                 i_cmd_full,
    output arpc_pkg::t_cmd                       o_cmd
);

    import arpc_pkg::*;

    logic [31:0] r_station_ip;
    logic        r_valid;
    t_cmd        r_cmd;

    logic        w_push;
    logic        w_accept;
    logic        w_keep;
    t_cmd        w_cmd;

    assign w_push     = r_valid && !i_cmd_full;
    assign o_in_stall = r_valid && i_cmd_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // classify: drop frames that need no work
    always_comb begin
        w_keep       = 1'b0;
        w_cmd.kind   = CMD_RESOLVE;
        w_cmd.ip     = i_in_word.target_ip;
        w_cmd.mac    = i_in_word.sender_mac;
        w_cmd.client = i_in_word.client_id;
        if (i_in_word.op == OP_RESOLVE) begin
            w_keep = 1'b1;
        end else if (i_in_word.arp_opcode == OPC_REQUEST) begin
            w_keep     = (i_in_word.target_ip == r_station_ip);
            w_cmd.kind = CMD_RESPOND;
            w_cmd.ip   = i_in_word.sender_ip;
        end else if (i_in_word.arp_opcode == OPC_REPLY) begin
            w_keep     = 1'b1;
            w_cmd.kind = CMD_LEARN;
            w_cmd.ip   = i_in_word.sender_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_ip <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == CFG_STATION_IP)) begin
                r_station_ip <= i_cfg_data[31:0];
            end
            if (w_accept && w_keep) begin
                r_valid <= 1'b1;
                r_cmd   <= w_cmd;
            end else if (w_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: sv/arpc_fifo.sv
module arpc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  arpc_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output arpc_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);

    import arpc_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_mem[r_wr_ptr] <= i_wr_cmd;
                r_wr_ptr        <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_cmd = r_mem[r_rd_ptr];

endmodule

FILE: sv/arpc_back.sv
module arpc_back #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpc_pkg::t_cmd      i_cmd,
    input  logic                i_cmd_empty,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpc_pkg::t_out_word o_out_word
);

    import arpc_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1);

    typedef struct packed {
        logic        complete;
        logic [15:0] client;
        logic [47:0] mac;
    } t_entry;

    localparam int unsigned EW = $bits(t_entry);

    typedef enum logic {
        S_LOOK,
        S_EXEC
    } t_state;

    t_state      r_state;
    logic [31:0] r_entry_ip [TABLE_ENTRIES];
    logic [FW-1:0] r_fill;
    t_cmd        r_cmd;
    logic        r_hit;
    logic [IW-1:0] r_idx;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [IW-1:0] w_hit_idx;
    logic          w_any_hit;
    logic          w_full;
    logic          w_go;
    logic [EW-1:0] w_rd_raw;
    t_entry        w_rd;
    logic          w_wr_en;
    t_entry        w_wr_data;
    logic          w_alloc;
    logic          w_emit;
    t_out_word     w_out;

    always_comb begin
        w_hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_hit[i] = (FW'(i) < r_fill) && (r_entry_ip[i] == i_cmd.ip);
            if (w_hit[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
            end
        end
    end

    assign w_any_hit = |w_hit;
    assign w_full    = (r_fill == FW'(TABLE_ENTRIES));
    assign o_cmd_pop = (r_state == S_LOOK) && !i_cmd_empty;
    assign w_go      = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign w_rd      = t_entry'(w_rd_raw);

    arpc_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_go && w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (o_cmd_pop),
        .i_rd_addr (w_hit_idx),
        .o_rd_data (w_rd_raw)
    );

    always_comb begin
        w_wr_en          = 1'b0;
        w_wr_data        = w_rd;
        w_alloc          = 1'b0;
        w_emit           = 1'b0;
        w_out.action     = ACT_ANSWER;
        w_out.out_ip     = r_cmd.ip;
        w_out.out_mac    = '0;
        w_out.out_client = '0;
        case (r_cmd.kind)
            CMD_RESOLVE: begin
                w_emit = 1'b1;
                if (r_hit && w_rd.complete) begin
                    w_out.out_mac    = w_rd.mac;
                    w_out.out_client = r_cmd.client;
                end else if (!r_hit && w_full) begin
                    w_out.action = ACT_FULL;
                end else begin
                    w_wr_en          = 1'b1;
                    w_wr_data.client = r_cmd.client;
                    if (!r_hit) begin
                        w_alloc            = 1'b1;
                        w_wr_data.complete = 1'b0;
                        w_wr_data.mac      = '0;
                    end
                    w_out.action  = ACT_REQUEST;
                    w_out.out_mac = BCAST_MAC;
                end
            end
            CMD_LEARN: begin
                if (r_hit) begin
                    w_wr_en            = 1'b1;
                    w_wr_data.complete = 1'b1;
                    w_wr_data.mac      = r_cmd.mac;
                    w_emit             = !w_rd.complete;
                    w_out.out_mac      = r_cmd.mac;
                    w_out.out_client   = w_rd.client;
                end else if (w_full) begin
                    w_emit       = 1'b1;
                    w_out.action = ACT_FULL;
                end else begin
                    w_wr_en            = 1'b1;
                    w_alloc            = 1'b1;
                    w_wr_data.complete = 1'b1;
                    w_wr_data.client   = '0;
                    w_wr_data.mac      = r_cmd.mac;
                end
            end
            CMD_RESPOND: begin
                w_emit        = 1'b1;
                w_out.action  = ACT_REPLY;
                w_out.out_mac = r_cmd.mac;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOOK;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go && w_emit) begin
                r_out_valid <= 1'b1;
                r_out_word  <= w_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOOK: begin
                    if (o_cmd_pop) begin
                        r_cmd   <= i_cmd;
                        r_hit   <= w_any_hit;
                        r_idx   <= w_any_hit ? w_hit_idx : r_fill[IW-1:0];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        if (w_alloc) begin
                            r_entry_ip[r_idx] <= r_cmd.ip;
                            r_fill            <= r_fill + 1'b1;
                        end
                        r_state <= S_LOOK;
                    end
                end
                default: begin
                    r_state <= S_LOOK;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: sv/arp_cache_and_responder.sv
// An accepted word passes the front command register, the queue, the table unit's lookup
// registers and output register. The table unit takes one word at a time (IP match and
// entry read, then entry update); words that need no work are dropped at the front.
// Reset: synchronous, active low; clears fill count, queue, handshakes and station IP.
// Entry contents are not cleared; entries beyond the fill count are never matched.
module arp_cache_and_responder #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [arpc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  arpc_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output arpc_pkg::t_out_word              o_out_word
);

    import arpc_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;

    arpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_cmd_valid (w_push),
        .i_cmd_full  (w_full),
        .o_cmd       (w_front_cmd)
    );

    arpc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wr_cmd (w_front_cmd),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_rd_cmd (w_queue_cmd),
        .o_empty  (w_empty)
    );

    arpc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_queue_cmd),
        .i_cmd_empty (w_empty),
        .o_cmd_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
